// File: sv/mru_page_cache_directory_defines.svh
// Assertion macros for the page cache directory checker.
// Depends on nothing; included by the checker file only.
`ifndef MRU_PAGE_CACHE_DIRECTORY_DEFINES_SVH
`define MRU_PAGE_CACHE_DIRECTORY_DEFINES_SVH

// same-cycle implication, disabled during reset
`define MPCD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define MPCD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/mpcd_pkg.sv
// Shared types and constants for the page cache directory.
// Used by the cell, the top level and the checker.
`default_nettype none

package mpcd_pkg;

   // request modes
   localparam logic MODE_LOOKUP = 1'b0;
   localparam logic MODE_INSERT = 1'b1;

   // configuration register indexes
   localparam int  CSR_INDEX_W   = 1;
   localparam int  CSR_DATA_W    = 5;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAPACITY  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WRITEBACK = 1'd1;
   localparam logic [CSR_DATA_W-1:0]  CAPACITY_RESET = 5'd16;

   typedef struct packed {
      logic        mode;
      logic [31:0] page_key;
      logic        dirty;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic [3:0]  slot;
      logic        page_dirty;
      logic        evicted;
      logic        writeback;
      logic [31:0] evicted_key;
   } rsp_type;

   // per-cycle control broadcast to every cell
   typedef struct packed {
      logic shift_all;   // new entry enters the front, whole row moves back
      logic hit_move;    // matched entry goes to front, cells above it move back
   } ctrl_type;

endpackage

`default_nettype wire

// File: sv/mpcd_cell.sv
// One position of the recency order: slot number, key, dirty mark, valid.
// Depends on mpcd_pkg for the control struct.
`default_nettype none

module mpcd_cell #(
   parameter int SLOT_W = 4
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire mpcd_pkg::ctrl_type ctrl,
   input  wire                    load,        // take the up_ entry in place
   input  wire  [31:0]            cmp_key,
   input  wire                    chain_in,    // match at a later position
   output logic                   chain_out,
   output logic                   match,
   input  wire                    up_valid,
   input  wire  [31:0]            up_key,
   input  wire                    up_dirty,
   input  wire  [SLOT_W-1:0]      up_slot,
   output logic                   valid,
   output logic [31:0]            key,
   output logic                   dirty,
   output logic [SLOT_W-1:0]      slot
);

   logic              valid_ff, valid_in;
   logic [31:0]       key_ff, key_in;
   logic              dirty_ff, dirty_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              shift;

   // compare and pass the match flag toward the front
   assign match     = valid_ff && (key_ff == cmp_key);
   assign chain_out = match | chain_in;
   assign shift     = ctrl.shift_all | (ctrl.hit_move & chain_out) | load;

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      dirty_in = dirty_ff;
      slot_in  = slot_ff;
      if (shift) begin
         valid_in = up_valid;
         key_in   = up_key;
         dirty_in = up_dirty;
         slot_in  = up_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      key_ff   <= key_in;
      dirty_ff <= dirty_in;
      slot_ff  <= slot_in;
   end

   assign valid = valid_ff;
   assign key   = key_ff;
   assign dirty = dirty_ff;
   assign slot  = slot_ff;

endmodule

`default_nettype wire

// File: sv/mru_page_cache_directory.sv
// Page cache directory, fully associative, most-recently-used replacement.
// Each accepted item has its result registered and strobed in the next cycle.
// Throughput 1 item per cycle; busy stays low. The figure is set by the key compare in
// every cell and the one-step shift of the row of cells, both done in the same cycle.
// Synchronous reset empties the directory, capacity 16, write-back off; no clearing pass.
`default_nettype none

module mru_page_cache_directory #(
   parameter int SLOTS = 16
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  start,
   output logic                                 busy,
   input  wire mpcd_pkg::req_type               req_item,
   output logic                                 rsp_valid,
   output mpcd_pkg::rsp_type                    rsp_item,
   input  wire                                  csr_we,
   input  wire  [mpcd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire  [mpcd_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int CMP_W  = (CNT_W > mpcd_pkg::CSR_DATA_W) ? CNT_W : mpcd_pkg::CSR_DATA_W;

   logic [mpcd_pkg::CSR_DATA_W-1:0] capacity_ff;
   logic                            writeback_ff;
   logic [CNT_W-1:0]                count_ff, count_in;
   logic                            rsp_valid_ff;
   mpcd_pkg::rsp_type               rsp_ff, rsp_in;

   // row of cells
   logic              c_valid [SLOTS];
   logic [31:0]       c_key   [SLOTS];
   logic              c_dirty [SLOTS];
   logic [SLOT_W-1:0] c_slot  [SLOTS];
   logic              c_match [SLOTS];
   logic              c_chain [SLOTS+1];

   mpcd_pkg::ctrl_type ctrl;
   logic               front_load;
   logic               accept;
   logic               any_hit;
   logic               is_insert;
   logic               full;
   logic [31:0]        hit_key;
   logic               hit_dirty;
   logic [SLOT_W-1:0]  hit_slot;
   logic               front_dirty;
   logic [31:0]        front_key;
   logic [SLOT_W-1:0]  front_slot;
   logic [CMP_W-1:0]   cap_x, eff_cap;

   assign busy      = 1'b0;
   assign accept    = start && !busy;
   assign is_insert = (req_item.mode == mpcd_pkg::MODE_INSERT);
   assign any_hit   = c_chain[0];
   assign c_chain[SLOTS] = 1'b0;

   genvar gi;
   generate
      for (gi = 0; gi < SLOTS; gi++) begin : g_cell
         if (gi == 0) begin : g_front
            mpcd_cell #(.SLOT_W(SLOT_W)) u_cell (
               .clock    (clock),
               .reset    (reset),
               .ctrl     (ctrl),
               .load     (front_load),
               .cmp_key  (req_item.page_key),
               .chain_in (c_chain[gi+1]),
               .chain_out(c_chain[gi]),
               .match    (c_match[gi]),
               .up_valid (1'b1),
               .up_key   (front_key),
               .up_dirty (front_dirty),
               .up_slot  (front_slot),
               .valid    (c_valid[gi]),
               .key      (c_key[gi]),
               .dirty    (c_dirty[gi]),
               .slot     (c_slot[gi])
            );
         end else begin : g_rest
            mpcd_cell #(.SLOT_W(SLOT_W)) u_cell (
               .clock    (clock),
               .reset    (reset),
               .ctrl     (ctrl),
               .load     (1'b0),
               .cmp_key  (req_item.page_key),
               .chain_in (c_chain[gi+1]),
               .chain_out(c_chain[gi]),
               .match    (c_match[gi]),
               .up_valid (c_valid[gi-1]),
               .up_key   (c_key[gi-1]),
               .up_dirty (c_dirty[gi-1]),
               .up_slot  (c_slot[gi-1]),
               .valid    (c_valid[gi]),
               .key      (c_key[gi]),
               .dirty    (c_dirty[gi]),
               .slot     (c_slot[gi])
            );
         end
      end
   endgenerate

   // matched entry; keys are unique among valid cells, so an OR of the hits
   always_comb begin
      hit_key   = '0;
      hit_dirty = 1'b0;
      hit_slot  = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (c_match[i]) begin
            hit_key   = hit_key | c_key[i];
            hit_dirty = hit_dirty | c_dirty[i];
            hit_slot  = hit_slot | c_slot[i];
         end
      end
   end

   // effective capacity: zero counts as one, saturate at the built slot count
   always_comb begin
      cap_x = CMP_W'(capacity_ff);
      if (capacity_ff == '0) begin
         eff_cap = CMP_W'(1);
      end else if (cap_x > CMP_W'(SLOTS)) begin
         eff_cap = CMP_W'(SLOTS);
      end else begin
         eff_cap = cap_x;
      end
   end

   assign full = (CMP_W'(count_ff) >= eff_cap) && (count_ff != '0);

   // request decode: new front entry, cell control, result, fill count
   always_comb begin
      ctrl        = '0;
      front_load  = 1'b0;
      count_in    = count_ff;
      front_key   = req_item.page_key;
      front_dirty = req_item.dirty;
      front_slot  = SLOT_W'(count_ff);
      rsp_in      = '0;
      if (any_hit) begin
         ctrl.hit_move = accept;
         front_key     = hit_key;
         front_dirty   = is_insert ? req_item.dirty : hit_dirty;
         front_slot    = hit_slot;
         rsp_in.hit        = 1'b1;
         rsp_in.slot       = 4'(hit_slot);
         rsp_in.page_dirty = front_dirty;
      end else if (is_insert) begin
         rsp_in.page_dirty = req_item.dirty;
         if (full) begin
            // evict the front entry and reuse its slot in place
            front_load         = accept;
            front_slot         = c_slot[0];
            rsp_in.slot        = 4'(c_slot[0]);
            rsp_in.evicted     = 1'b1;
            rsp_in.evicted_key = c_key[0];
            rsp_in.writeback   = c_dirty[0] & writeback_ff;
         end else begin
            ctrl.shift_all = accept;
            rsp_in.slot    = 4'(count_ff);
            if (accept) begin
               count_in = count_ff + CNT_W'(1);
            end
         end
      end
   end

   // configuration, fill count and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= mpcd_pkg::CAPACITY_RESET;
         writeback_ff <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               mpcd_pkg::CSR_CAPACITY:  capacity_ff  <= csr_wdata;
               mpcd_pkg::CSR_WRITEBACK: writeback_ff <= csr_wdata[0];
               default: ;
            endcase
         end
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
      end
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

`default_nettype wire

// File: sv/mpcd_checker.sv
// Port-level checks for the page cache directory, bound to the top level.
// Depends on mpcd_pkg and the assertion macro header.
`default_nettype none
`include "mru_page_cache_directory_defines.svh"

module mpcd_checker (
   input wire                    clock,
   input wire                    reset,
   input wire                    start,
   input wire                    busy,
   input wire mpcd_pkg::req_type req_item,
   input wire                    rsp_valid,
   input wire mpcd_pkg::rsp_type rsp_item
);

   // every accepted item gives exactly one result in the next cycle
   `MPCD_ASSERT_NEXT(a_rsp_follows, clock, reset, start && !busy, rsp_valid, "result missing")
   `MPCD_ASSERT_NEXT(a_no_extra, clock, reset, !(start && !busy), !rsp_valid, "result invented")
   // an eviction never comes with a hit, and write-back only with an eviction
   `MPCD_ASSERT_NOW(a_evict_miss, clock, reset, rsp_valid && rsp_item.evicted, !rsp_item.hit, "evict on hit")
   `MPCD_ASSERT_NOW(a_wb_evict, clock, reset, rsp_valid && rsp_item.writeback, rsp_item.evicted, "write-back without eviction")
   // a lookup miss reports an all-zero item
   `MPCD_ASSERT_NOW(a_miss_zero, clock, reset, rsp_valid && !rsp_item.hit && $past(req_item.mode) == mpcd_pkg::MODE_LOOKUP, rsp_item == '0, "lookup miss not zero")

endmodule

bind mru_page_cache_directory mpcd_checker u_mpcd_checker (
   .clock    (clock),
   .reset    (reset),
   .start    (start),
   .busy     (busy),
   .req_item (req_item),
   .rsp_valid(rsp_valid),
   .rsp_item (rsp_item)
);

`default_nettype wire

// File: sim/mru_page_cache_directory_tb.sv
// Self-checking bench for the MRU page cache directory: directed table, then random traffic.
// Needs mpcd_pkg and mru_page_cache_directory only; a built-in predictor checks every result.

module mru_page_cache_directory_tb;

   localparam int SLOTS     = 16;
   localparam int STALL_MAX = 1000;
   localparam int SEG_ITEMS = 180;
   localparam int NUM_SEGS  = 9;
   localparam int POOL_SIZE = 24;
   // capacity per random segment, index 0 first: 1, 16, 0, 31, 2, 8, 3, 16, 5
   localparam logic [NUM_SEGS-1:0][4:0] SEG_CAPS =
      {5'd5, 5'd16, 5'd3, 5'd8, 5'd2, 5'd31, 5'd0, 5'd16, 5'd1};

   // one row of the directed table: a register setting or an item
   typedef struct packed {
      logic              is_cfg;
      mpcd_pkg::req_type req;
      logic              known;
      mpcd_pkg::rsp_type want;
      logic [4:0]        cap;
      logic              wb;
   } plan_row_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             start = 1'b0;
   logic                             busy;
   mpcd_pkg::req_type                req_item = '0;
   logic                             rsp_valid;
   mpcd_pkg::rsp_type                rsp_item;
   logic                             csr_we = 1'b0;
   logic [mpcd_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [mpcd_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   // predicted directory contents and register settings
   logic [31:0] dir_key [SLOTS];
   logic        dir_dirty [SLOTS];
   int          mru_order [SLOTS];
   int          filled;
   logic [4:0]  cap_setting;
   logic        wb_setting;

   mpcd_pkg::rsp_type pending_rsp [$];
   plan_row_type      plan [$];
   logic [31:0]       key_pool [POOL_SIZE];
   mpcd_pkg::rsp_type oldest;
   int          sender_idle = 36;
   int          err_count = 0;
   int          quiet_cycles = 0;
   int          n_items = 0, n_hits = 0, n_evicts = 0, n_wbacks = 0, n_settings = 0;

   mru_page_cache_directory #(.SLOTS(SLOTS)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic mpcd_pkg::req_type mk_req(logic mode, logic [31:0] key, logic dirty);
      mpcd_pkg::req_type r;
      r.mode     = mode;
      r.page_key = key;
      r.dirty    = dirty;
      return r;
   endfunction

   function automatic mpcd_pkg::rsp_type mk_rsp(logic hit, logic [3:0] slot, logic pdirty,
                                                logic ev, logic wb, logic [31:0] ev_key);
      mpcd_pkg::rsp_type o;
      o.hit         = hit;
      o.slot        = slot;
      o.page_dirty  = pdirty;
      o.evicted     = ev;
      o.writeback   = wb;
      o.evicted_key = ev_key;
      return o;
   endfunction

   function automatic int usable_slots(logic [4:0] cap);
      if (cap == 0) return 1;
      if (cap > SLOTS) return SLOTS;
      return int'(cap);
   endfunction

   // lookup or insert against the predicted directory; updates it and returns the result
   function automatic mpcd_pkg::rsp_type directory_access(mpcd_pkg::req_type r);
      mpcd_pkg::rsp_type o;
      int      pos;
      int      s;
      int      i;
      o   = '0;
      pos = filled;
      for (i = 0; i < filled && pos == filled; i++) begin
         if (dir_key[mru_order[i]] == r.page_key) pos = i;
      end
      if (pos < filled) begin
         // hit: entry moves to the front
         s = mru_order[pos];
         for (i = pos; i > 0; i--) mru_order[i] = mru_order[i-1];
         mru_order[0] = s;
         if (r.mode == mpcd_pkg::MODE_INSERT) dir_dirty[s] = r.dirty;
         o.hit        = 1'b1;
         o.slot       = s[3:0];
         o.page_dirty = dir_dirty[s];
      end else if (r.mode == mpcd_pkg::MODE_INSERT) begin
         if (filled >= usable_slots(cap_setting) && filled > 0) begin
            // full: the front entry gives up its slot, order stays
            s             = mru_order[0];
            o.evicted     = 1'b1;
            o.evicted_key = dir_key[s];
            o.writeback   = dir_dirty[s] & wb_setting;
         end else begin
            s = filled;
            for (i = filled; i > 0; i--) mru_order[i] = mru_order[i-1];
            mru_order[0] = s;
            filled++;
         end
         dir_key[s]   = r.page_key;
         dir_dirty[s] = r.dirty;
         o.slot       = s[3:0];
         o.page_dirty = r.dirty;
      end
      return o;
   endfunction

   // random request: mostly keys from a pool sized to the capacity, so hits happen
   function automatic mpcd_pkg::req_type random_req();
      int span;
      logic [31:0] key;
      span = usable_slots(cap_setting) + 3;
      if (span > POOL_SIZE - 1) span = POOL_SIZE - 1;
      if ($urandom_range(0, 99) < 85) key = key_pool[$urandom_range(0, span)];
      else key = $urandom;
      return mk_req($urandom_range(0, 1) ? mpcd_pkg::MODE_INSERT : mpcd_pkg::MODE_LOOKUP,
                    key, 1'($urandom_range(0, 1)));
   endfunction

   // present one item, wait for acceptance, queue its expected result
   task automatic send_item(input mpcd_pkg::req_type r, input logic known,
                            input mpcd_pkg::rsp_type want);
      mpcd_pkg::rsp_type model_out;
      while ($urandom_range(0, 99) < sender_idle) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (busy);
      model_out = directory_access(r);
      if (known) model_out = want;
      pending_rsp.push_back(model_out);
      n_items++;
      if (model_out.hit) n_hits++;
      if (model_out.evicted) n_evicts++;
      if (model_out.writeback) n_wbacks++;
   endtask

   // stop sending and let every outstanding result come back
   task automatic settle();
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // both registers, one per cycle; the block is idle here
   task automatic write_config(input logic [4:0] cap, input logic wb);
      csr_we    <= 1'b1;
      csr_index <= mpcd_pkg::CSR_CAPACITY;
      csr_wdata <= cap;
      @(posedge clock);
      cap_setting = cap;
      csr_index <= mpcd_pkg::CSR_WRITEBACK;
      csr_wdata <= {{(mpcd_pkg::CSR_DATA_W-1){1'b0}}, wb};
      @(posedge clock);
      wb_setting = wb;
      csr_we <= 1'b0;
      n_settings++;
   endtask

   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
      if (act_v !== exp_v) begin
         err_count++;
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
      end
   endtask

   // result checking and stall watchdog
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            err_count++;
            $display("%0t: result with nothing expected, got %h", $time, rsp_item);
         end else begin
            oldest = pending_rsp[0];
            pending_rsp.delete(0);
            check_field("hit", oldest.hit, rsp_item.hit);
            check_field("slot", oldest.slot, rsp_item.slot);
            check_field("page_dirty", oldest.page_dirty, rsp_item.page_dirty);
            check_field("evicted", oldest.evicted, rsp_item.evicted);
            check_field("writeback", oldest.writeback, rsp_item.writeback);
            check_field("evicted_key", oldest.evicted_key, rsp_item.evicted_key);
         end
      end
      if (reset || (start && !busy) || rsp_valid || csr_we) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_MAX) begin
            $display("%0t: no progress for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, pending_rsp.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   initial begin
      int seg;
      int i;
      // predicted state after reset
      for (i = 0; i < SLOTS; i++) begin
         dir_key[i]   = '0;
         dir_dirty[i] = 1'b0;
         mru_order[i] = 0;
      end
      filled      = 0;
      cap_setting = mpcd_pkg::CAPACITY_RESET;
      wb_setting  = 1'b0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table: empty directory, key extremes, hits, dirty updates
      plan.push_back('{1'b0, mk_req(mpcd_pkg::MODE_LOOKUP, 32'h0, 1'b0), 1'b1,
                       mk_rsp(0, 0, 0, 0, 0, 32'h0), 5'd0, 1'b0});
      plan.push_back('{1'b0, mk_req(mpcd_pkg::MODE_INSERT, 32'h0, 1'b1), 1'b1,
                       mk_rsp(0, 0, 1, 0, 0, 32'h0), 5'd0, 1'b0});
      plan.push_back('{1'b0, mk_req(mpcd_pkg::MODE_INSERT, 32'hFFFF_FFFF, 1'b0), 1'b1,
                       mk_rsp(0, 1, 0, 0, 0, 32'h0), 5'd0, 1'b0});
      plan.push_back('{1'b0, mk_req(mpcd_pkg::MODE_LOOKUP, 32'h0, 1'b0), 1'b1,
                       mk_rsp(1, 0, 1, 0, 0, 32'h0), 5'd0, 1'b0});
      plan.push_back('{1'b0, mk_req(mpcd_pkg::MODE_LOOKUP, 32'hFFFF_FFFE, 1'b1), 1'b1,
                       mk_rsp(0, 0, 0, 0, 0, 32'h0), 5'd0, 1'b0});
      // insert of a present key only rewrites the dirty mark
      plan.push_back('{1'b0, mk_req(mpcd_pkg::MODE_INSERT, 32'hFFFF_FFFF, 1'b1), 1'b1,
                       mk_rsp(1, 1, 1, 0, 0, 32'h0), 5'd0, 1'b0});
      // lookup ignores the dirty input
      plan.push_back('{1'b0, mk_req(mpcd_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, 1'b1), 1'b1,
                       mk_rsp(1, 1, 1, 0, 0, 32'h0), 5'd0, 1'b0});
      // capacity dropped below the fill level, write-back on
      plan.push_back('{1'b1, '0, 1'b0, '0, 5'd1, 1'b1});
      plan.push_back('{1'b0, mk_req(mpcd_pkg::MODE_INSERT, 32'hA5A5_A5A5, 1'b0), 1'b1,
                       mk_rsp(0, 1, 0, 1, 1, 32'hFFFF_FFFF), 5'd0, 1'b0});
      plan.push_back('{1'b0, mk_req(mpcd_pkg::MODE_INSERT, 32'h5A5A_5A5A, 1'b1), 1'b1,
                       mk_rsp(0, 1, 1, 1, 0, 32'hA5A5_A5A5), 5'd0, 1'b0});
      plan.push_back('{1'b0, mk_req(mpcd_pkg::MODE_INSERT, 32'h5A5A_5A5A, 1'b0), 1'b0,
                       '0, 5'd0, 1'b0});
      plan.push_back('{1'b0, mk_req(mpcd_pkg::MODE_LOOKUP, 32'h0, 1'b0), 1'b0,
                       '0, 5'd0, 1'b0});
      plan.push_back('{1'b0, mk_req(mpcd_pkg::MODE_INSERT, 32'h1234_5678, 1'b1), 1'b0,
                       '0, 5'd0, 1'b0});
      // zero capacity behaves as one; dirty eviction without write-back
      plan.push_back('{1'b1, '0, 1'b0, '0, 5'd0, 1'b0});
      plan.push_back('{1'b0, mk_req(mpcd_pkg::MODE_INSERT, 32'h8000_0000, 1'b0), 1'b0,
                       '0, 5'd0, 1'b0});
      plan.push_back('{1'b0, mk_req(mpcd_pkg::MODE_LOOKUP, 32'h1234_5678, 1'b0), 1'b0,
                       '0, 5'd0, 1'b0});
      // oversize capacity saturates, free slots again
      plan.push_back('{1'b1, '0, 1'b0, '0, 5'd31, 1'b1});
      plan.push_back('{1'b0, mk_req(mpcd_pkg::MODE_INSERT, 32'h0000_0001, 1'b1), 1'b0,
                       '0, 5'd0, 1'b0});
      plan.push_back('{1'b0, mk_req(mpcd_pkg::MODE_INSERT, 32'h7FFF_FFFF, 1'b0), 1'b0,
                       '0, 5'd0, 1'b0});
      plan.push_back('{1'b0, mk_req(mpcd_pkg::MODE_LOOKUP, 32'h5A5A_5A5A, 1'b0), 1'b0,
                       '0, 5'd0, 1'b0});
      plan.push_back('{1'b0, mk_req(mpcd_pkg::MODE_INSERT, 32'h8000_0000, 1'b1), 1'b0,
                       '0, 5'd0, 1'b0});

      foreach (plan[row]) begin
         if (plan[row].is_cfg) begin
            settle();
            write_config(plan[row].cap, plan[row].wb);
         end else begin
            send_item(plan[row].req, plan[row].known, plan[row].want);
         end
      end

      // random segments: each its own setting, sender idling 36%, then 50%, then none
      for (i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;
      for (seg = 0; seg < NUM_SEGS; seg++) begin
         settle();
         write_config(SEG_CAPS[seg], 1'($urandom_range(0, 1)));
         sender_idle = (seg < 3) ? 36 : (seg < 6) ? 50 : 0;
         for (i = 0; i < 8; i++) key_pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom;
         repeat (SEG_ITEMS) send_item(random_req(), 1'b0, '0);
      end
      settle();

      $display("Covered %0d items across %0d register settings:", n_items, n_settings);
      $display("  %0d hits, %0d evictions, %0d write-back requests", n_hits, n_evicts,
               n_wbacks);
      if (err_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
